### design/iee_pkg.sv
// Shared types and constants of the infix expression evaluator.
package iee_pkg;

    // ASCII characters that the parser recognizes
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_OPEN  = 8'h28;
    localparam logic [7:0] CHR_CLOSE = 8'h29;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int OPCODE_W = 2;
    localparam int HALF_W   = 32;

    // Operator stack entry codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_NONE  = 2'd0,
        OP_PLUS  = 2'd1,
        OP_STAR  = 2'd2,
        OP_PAREN = 2'd3
    } opcode_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ERR_DEPTH     = 2'd1;
    localparam logic [STATUS_W-1:0] ERR_MALFORMED = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_STAR,
        S_CLOSE,
        S_RELOAD,
        S_POP,
        S_OPND,
        S_ALU,
        S_FLUSH
    } state_t;

    // Request to the shared arithmetic unit
    typedef struct packed {
        logic start;
        logic mul;
    } alu_req_t;

endpackage

### design/iee_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iee_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/iee_alu.sv
// Shared add / multiply unit: registered add, 64-bit wrapping multiply on one 32x32 multiplier.
module iee_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  iee_pkg::alu_req_t              req,
    input  logic [iee_pkg::VALUE_W-1:0]    a,
    input  logic [iee_pkg::VALUE_W-1:0]    b,
    output logic                           done,
    output logic [iee_pkg::VALUE_W-1:0]    result
);
    import iee_pkg::*;

    logic               busy_reg, busy_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [VALUE_W-1:0] a_reg, a_next;
    logic [VALUE_W-1:0] b_reg, b_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [VALUE_W-1:0] prod_reg, prod_next;
    logic [HALF_W-1:0]  mul_a, mul_b;
    logic [VALUE_W-1:0] prod_w;
    logic [VALUE_W-1:0] prod_hi;

    // Operand halves for each partial product: lo*lo, hi*lo, lo*hi
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = b_reg[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = a_reg[VALUE_W-1:HALF_W];
                mul_b = b_reg[HALF_W-1:0];
            end
            default:
            begin
                mul_a = a_reg[HALF_W-1:0];
                mul_b = b_reg[VALUE_W-1:HALF_W];
            end
        endcase
    end

    assign prod_w  = VALUE_W'(mul_a) * VALUE_W'(mul_b);
    assign prod_hi = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            case (cnt_reg)
                2'd0:
                begin
                    prod_next = prod_w;
                end
                2'd1:
                begin
                    acc_next  = prod_reg;
                    prod_next = prod_w;
                end
                2'd2:
                begin
                    acc_next  = acc_reg + prod_hi;
                    prod_next = prod_w;
                end
                default:
                begin
                    acc_next  = acc_reg + prod_hi;
                    done_next = 1'b1;
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (req.start)
        begin
            a_next = a;
            b_next = b;
            if (req.mul)
            begin
                busy_next = 1'b1;
                cnt_next  = 2'd0;
            end
            else
            begin
                acc_next  = a + b;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;
endmodule

### design/infix_expression_evaluator.sv
// Infix expression evaluator: shunting-yard parser fused with stack evaluation.
//
//   Channel  | Direction | Payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | tdata[7:0] symbol, tlast last_symbol
//   m_axis   | out       | tdata[63:0] value, tuser[1:0] status
//
// Steps: a digit, '+', '(' or an ignored character is taken in S_IDLE and handled in
// S_DECODE; a '*' also passes S_STAR, and a ')' passes S_CLOSE and, when it meets its
// '(' at once, S_RELOAD. Each operator popped from the stack passes S_POP, S_OPND
// (operand fetch), S_ALU (the shared arithmetic unit) and the recheck of the stack top;
// the multiply runs three 32x32 partial products on one multiplier. ')', '*' and the
// final flush repeat that pop as often as needed; the last character adds a flush step.
// Reset clears counts and error state; stack contents are not cleared.
// A pending result waits in the output register; the final flush stalls only if a
// new result is ready while the previous one has not been taken.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] symbol
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [iee_pkg::VALUE_W-1:0]   m_axis_tdata,  // [63:0] value
    output logic [iee_pkg::STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);
    import iee_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    logic [7:0]           sym_reg, sym_next;
    logic                 last_reg, last_next;
    logic [CW-1:0]        oc_reg, oc_next;
    logic [CW-1:0]        vc_reg, vc_next;
    logic [STATUS_W-1:0]  err_reg, err_next;
    opcode_t              top_op_reg, top_op_next;
    logic [VALUE_W-1:0]   tos_reg, tos_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   out_value_reg, out_value_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;

    // Stack memory ports
    logic                 vram_we;
    logic [AW-1:0]        vram_waddr, vram_raddr;
    logic [VALUE_W-1:0]   vram_wdata, vram_rdata;
    logic                 oram_we;
    logic [AW-1:0]        oram_waddr, oram_raddr;
    logic [OPCODE_W-1:0]  oram_wdata, oram_rdata;

    // Arithmetic unit
    alu_req_t             alu_req;
    logic                 alu_done;
    logic [VALUE_W-1:0]   alu_result;

    // Helpers
    logic                 is_digit;
    logic [VALUE_W-1:0]   digit_val;
    logic [CW-1:0]        oc_m2, vc_m2;
    logic                 do_push;
    opcode_t              push_code;
    state_t               after_state;

    assign is_digit    = (sym_reg >= CHR_ZERO) && (sym_reg <= CHR_NINE);
    assign digit_val   = VALUE_W'(sym_reg - CHR_ZERO);
    assign oc_m2       = oc_reg - CW'(2);
    assign vc_m2       = vc_reg - CW'(2);
    assign after_state = last_reg ? S_FLUSH : S_IDLE;

    iee_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    iee_ram #(
        .WIDTH (OPCODE_W),
        .DEPTH (STACK_DEPTH)
    ) u_op_ram (
        .clk   (clk),
        .we    (oram_we),
        .waddr (oram_waddr),
        .wdata (oram_wdata),
        .raddr (oram_raddr),
        .rdata (oram_rdata)
    );

    iee_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (tos_reg),
        .b      (vram_rdata),
        .done   (alu_done),
        .result (alu_result)
    );

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        oc_next         = oc_reg;
        vc_next         = vc_reg;
        err_next        = err_reg;
        top_op_next     = top_op_reg;
        tos_next        = tos_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        vram_we         = 1'b0;
        vram_waddr      = vc_reg[AW-1:0];
        vram_wdata      = digit_val;
        vram_raddr      = vc_m2[AW-1:0];
        oram_we         = 1'b0;
        oram_waddr      = oc_reg[AW-1:0];
        oram_raddr      = oc_m2[AW-1:0];
        alu_req         = '0;
        do_push         = 1'b0;
        push_code       = OP_PLUS;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sym_next   = s_axis_tdata;
                    last_next  = s_axis_tlast;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = after_state;
                if (err_reg == ERR_NONE)
                begin
                    if (is_digit)
                    begin
                        if (vc_reg == FULL)
                        begin
                            err_next = ERR_DEPTH;
                        end
                        else
                        begin
                            vram_we  = 1'b1;
                            tos_next = digit_val;
                            vc_next  = vc_reg + CW'(1);
                        end
                    end
                    else if (sym_reg == CHR_PLUS)
                    begin
                        do_push   = 1'b1;
                        push_code = OP_PLUS;
                    end
                    else if (sym_reg == CHR_OPEN)
                    begin
                        do_push   = 1'b1;
                        push_code = OP_PAREN;
                    end
                    else if (sym_reg == CHR_STAR)
                    begin
                        state_next = S_STAR;
                    end
                    else if (sym_reg == CHR_CLOSE)
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_STAR:
            begin
                // pop pending additions, then push the star
                if (err_reg == ERR_NONE && oc_reg != '0 && top_op_reg == OP_PLUS)
                begin
                    ret_next   = S_STAR;
                    state_next = S_POP;
                end
                else
                begin
                    do_push    = (err_reg == ERR_NONE);
                    push_code  = OP_STAR;
                    state_next = after_state;
                end
            end
            S_CLOSE:
            begin
                if (err_reg != ERR_NONE)
                begin
                    state_next = after_state;
                end
                else if (oc_reg == '0)
                begin
                    err_next   = ERR_MALFORMED;
                    state_next = after_state;
                end
                else if (top_op_reg == OP_PAREN)
                begin
                    // drop the parenthesis, fetch the entry below it
                    oc_next    = oc_reg - CW'(1);
                    state_next = S_RELOAD;
                end
                else
                begin
                    ret_next   = S_CLOSE;
                    state_next = S_POP;
                end
            end
            S_RELOAD:
            begin
                top_op_next = opcode_t'(oram_rdata);
                state_next  = after_state;
            end
            S_POP:
            begin
                // pop one operator; read new top and second value
                oc_next = oc_reg - CW'(1);
                if ((top_op_reg != OP_PLUS && top_op_reg != OP_STAR) || vc_reg < CW'(2))
                begin
                    err_next   = ERR_MALFORMED;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_OPND;
                end
            end
            S_OPND:
            begin
                alu_req.start = 1'b1;
                alu_req.mul   = (top_op_reg == OP_STAR);
                top_op_next   = opcode_t'(oram_rdata);
                state_next    = S_ALU;
            end
            S_ALU:
            begin
                if (alu_done)
                begin
                    tos_next   = alu_result;
                    vram_we    = 1'b1;
                    vram_waddr = vc_m2[AW-1:0];
                    vram_wdata = alu_result;
                    vc_next    = vc_reg - CW'(1);
                    state_next = ret_reg;
                end
            end
            S_FLUSH:
            begin
                if (err_reg == ERR_NONE && oc_reg != '0)
                begin
                    ret_next   = S_FLUSH;
                    state_next = S_POP;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    if (err_reg == ERR_NONE && vc_reg == '0)
                    begin
                        out_status_next = ERR_MALFORMED;
                    end
                    else
                    begin
                        out_status_next = err_reg;
                    end
                    out_value_next = (err_reg == ERR_NONE && vc_reg != '0) ? tos_reg : '0;
                    oc_next        = '0;
                    vc_next        = '0;
                    err_next       = ERR_NONE;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Operator push shared by '+', '(' and '*'
        if (do_push)
        begin
            if (oc_reg == FULL)
            begin
                err_next = ERR_DEPTH;
            end
            else
            begin
                oram_we     = 1'b1;
                top_op_next = push_code;
                oc_next     = oc_reg + CW'(1);
            end
        end
        oram_wdata = push_code;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            oc_reg        <= '0;
            vc_reg        <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            oc_reg        <= oc_next;
            vc_reg        <= vc_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        top_op_reg     <= top_op_next;
        tos_reg        <= tos_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    // A failed expression reports a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ERR_NONE |-> m_axis_tdata == '0)
        else $error("error result carries a nonzero value");

    // Status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser == ERR_NONE || m_axis_tuser == ERR_DEPTH ||
                          m_axis_tuser == ERR_MALFORMED)
        else $error("invalid status code");

    // Arithmetic completion only arrives while the sequencer waits for it
    a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> state_reg == S_ALU)
        else $error("arithmetic result arrived outside the wait state");

    // Stack counts stay within the stack depth
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        oc_reg <= FULL && vc_reg <= FULL)
        else $error("stack count beyond depth");
`endif
endmodule
